// ===== sv/seg_isect_pkg.sv =====
package seg_isect_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = 24;

  // derived widths
  localparam int DW   = COORD_BITS + 1;          // coordinate difference
  localparam int PW   = 2 * DW;                  // product of two differences
  localparam int DETW = PW + 1;                  // determinant / numerators
  localparam int TW   = DETW - 1;                // magnitude of normalized terms
  localparam int QW   = COORD_BITS + FRAC_BITS;  // quotient bits
  localparam int MW   = TW + COORD_BITS;         // tn * |delta|
  localparam int NW   = MW + FRAC_BITS;          // dividend
  localparam int VW   = COORD_BITS + FRAC_BITS + 2;
  localparam int IN_TW  = ((8 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FW = 1 + 2 * OUT_BITS;
  localparam int OUT_TW = ((OUT_FW + 7) / 8) * 8;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic                         nx;
    logic                         ny;
  } side_t;
endpackage

// ===== sv/segment_intersection.sv =====
// Segment crossing test with fixed-point crossing point. Fully pipelined: one
// segment pair may enter every cycle while the output item is taken; the
// restoring divider produces one quotient bit per stage for x and y side by
// side. The whole pipeline advances together and
// holds while the output item is not taken. cross_x/cross_y carry FRAC_BITS
// fraction bits, truncated toward zero, and read zero when hit is low.
// Parallel, collinear and zero-length segments report no hit.
module segment_intersection (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [seg_isect_pkg::IN_TW-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // hit, cross_x, cross_y, zero pad
  output logic [seg_isect_pkg::OUT_TW-1:0] m_tdata
);
  import seg_isect_pkg::*;

  localparam int C = COORD_BITS;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic signed [C-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = s_tdata[0*C +: C];
  assign y1 = s_tdata[1*C +: C];
  assign x2 = s_tdata[2*C +: C];
  assign y2 = s_tdata[3*C +: C];
  assign x3 = s_tdata[4*C +: C];
  assign y3 = s_tdata[5*C +: C];
  assign x4 = s_tdata[6*C +: C];
  assign y4 = s_tdata[7*C +: C];

  logic v1, v2, v3, v4, v5, v6;

  // stage 1: differences
  logic signed [DW-1:0] a1, b1, c1, e1, f1, g1, dx1, dy1;
  logic signed [C-1:0]  px1, py1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      a1  <= DW'(x1) - DW'(x2);
      b1  <= DW'(y3) - DW'(y4);
      c1  <= DW'(y1) - DW'(y2);
      e1  <= DW'(x3) - DW'(x4);
      f1  <= DW'(x1) - DW'(x3);
      g1  <= DW'(y1) - DW'(y3);
      dx1 <= DW'(x2) - DW'(x1);
      dy1 <= DW'(y2) - DW'(y1);
      px1 <= x1;
      py1 <= y1;
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p1, p2, p3, p4, p5, p6;
  logic signed [DW-1:0] dx2, dy2;
  logic signed [C-1:0]  px2, py2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      p1 <= a1 * b1;
      p2 <= c1 * e1;
      p3 <= f1 * b1;
      p4 <= g1 * e1;
      p5 <= c1 * f1;
      p6 <= a1 * g1;
      dx2 <= dx1;
      dy2 <= dy1;
      px2 <= px1;
      py2 <= py1;
    end
  end

  // stage 3: determinant and numerators
  logic signed [DETW-1:0] d3, tn3, un3;
  logic signed [DW-1:0]   dx3, dy3;
  logic signed [C-1:0]    px3, py3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      d3  <= DETW'(p1) - DETW'(p2);
      tn3 <= DETW'(p3) - DETW'(p4);
      un3 <= DETW'(p5) - DETW'(p6);
      dx3 <= dx2;
      dy3 <= dy2;
      px3 <= px2;
      py3 <= py2;
    end
  end

  // stage 4: make the denominator positive, delta magnitudes
  logic signed [DETW-1:0] d4, tn4, un4;
  logic [C-1:0]           mx4, my4;
  logic                   nx4, ny4;
  logic signed [C-1:0]    px4, py4;
  logic signed [DW-1:0]   adx, ady;
  assign adx = dx3[DW-1] ? -dx3 : dx3;
  assign ady = dy3[DW-1] ? -dy3 : dy3;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      d4  <= d3[DETW-1] ? -d3 : d3;
      tn4 <= d3[DETW-1] ? -tn3 : tn3;
      un4 <= d3[DETW-1] ? -un3 : un3;
      mx4 <= adx[C-1:0];
      my4 <= ady[C-1:0];
      nx4 <= dx3[DW-1];
      ny4 <= dy3[DW-1];
      px4 <= px3;
      py4 <= py3;
    end
  end

  // stage 5: range tests on t and u
  logic [TW-1:0] d5, tn5;
  logic [C-1:0]  mx5, my5;
  side_t         sd5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      sd5.hit <= (d4 != '0) && !tn4[DETW-1] && (tn4 <= d4) && !un4[DETW-1] && (un4 <= d4);
      sd5.px  <= px4;
      sd5.py  <= py4;
      sd5.nx  <= nx4;
      sd5.ny  <= ny4;
      d5  <= d4[TW-1:0];
      tn5 <= tn4[TW-1:0];
      mx5 <= mx4;
      my5 <= my4;
    end
  end

  // stage 6: dividends tn * |delta| * 2^F
  logic [NW-1:0] nx_w, ny_w;
  assign nx_w = NW'(MW'(tn5) * MW'(mx5)) << FRAC_BITS;
  assign ny_w = NW'(MW'(tn5) * MW'(my5)) << FRAC_BITS;

  logic [TW-1:0] rx [0:QW];
  logic [TW-1:0] ry [0:QW];
  logic [QW-1:0] lx [0:QW];
  logic [QW-1:0] ly [0:QW];
  logic [QW-1:0] qx [0:QW];
  logic [QW-1:0] qy [0:QW];
  logic [TW-1:0] dd [0:QW];
  side_t         sd [0:QW];
  logic          vd [0:QW];

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      rx[0] <= nx_w[NW-1:QW];
      ry[0] <= ny_w[NW-1:QW];
      lx[0] <= nx_w[QW-1:0];
      ly[0] <= ny_w[QW-1:0];
      qx[0] <= '0;
      qy[0] <= '0;
      dd[0] <= d5;
      sd[0] <= sd5;
    end
  end
  assign vd[0] = v6;

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [TW:0] tx, ty;
    logic        gx, gy;
    logic [TW:0] sx, sy;
    logic        vk;
    assign tx = {rx[k], lx[k][QW-1-k]};
    assign ty = {ry[k], ly[k][QW-1-k]};
    assign gx = tx >= {1'b0, dd[k]};
    assign gy = ty >= {1'b0, dd[k]};
    assign sx = gx ? tx - {1'b0, dd[k]} : tx;
    assign sy = gy ? ty - {1'b0, dd[k]} : ty;
    always_ff @(posedge clk) begin
      if (rst) vk <= 1'b0;
      else if (en) vk <= vd[k];
      if (en) begin
        rx[k+1] <= sx[TW-1:0];
        ry[k+1] <= sy[TW-1:0];
        lx[k+1] <= lx[k];
        ly[k+1] <= ly[k];
        qx[k+1] <= {qx[k][QW-2:0], gx};
        qy[k+1] <= {qy[k][QW-2:0], gy};
        dd[k+1] <= dd[k];
        sd[k+1] <= sd[k];
      end
    end
    assign vd[k+1] = vk;
  end

  // final: add to the start point, truncate toward zero
  side_t sf;
  assign sf = sd[QW];
  logic signed [VW-1:0] pvx, pvy, vx, vy, cx, cy;
  assign pvx = VW'(sf.px) <<< FRAC_BITS;
  assign pvy = VW'(sf.py) <<< FRAC_BITS;
  assign vx  = sf.nx ? pvx - signed'({2'b00, qx[QW]}) : pvx + signed'({2'b00, qx[QW]});
  assign vy  = sf.ny ? pvy - signed'({2'b00, qy[QW]}) : pvy + signed'({2'b00, qy[QW]});
  always_comb begin
    cx = vx;
    if (rx[QW] != '0) begin
      if (!sf.nx && vx < 0) cx = vx + VW'(1);
      else if (sf.nx && vx > 0) cx = vx - VW'(1);
    end
    cy = vy;
    if (ry[QW] != '0) begin
      if (!sf.ny && vy < 0) cy = vy + VW'(1);
      else if (sf.ny && vy > 0) cy = vy - VW'(1);
    end
  end

  logic signed [VW+OUT_BITS-1:0] ex, ey;
  assign ex = (VW+OUT_BITS)'(cx);
  assign ey = (VW+OUT_BITS)'(cy);

  logic                hit_o;
  logic [OUT_BITS-1:0] ox, oy;
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= vd[QW];
    if (en) begin
      hit_o <= sf.hit;
      ox    <= sf.hit ? ex[OUT_BITS-1:0] : '0;
      oy    <= sf.hit ? ey[OUT_BITS-1:0] : '0;
    end
  end

  assign m_tdata = OUT_TW'({oy, ox, hit_o});
endmodule

// ===== verif/segment_intersection_tb.sv =====
`timescale 1ns / 100ps

module segment_intersection_tb;
  import seg_isect_pkg::*;

  typedef struct packed {
    logic                hit;
    logic [OUT_BITS-1:0] cx;
    logic [OUT_BITS-1:0] cy;
  } crossing_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_TW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_TW-1:0] m_tdata;

  logic [IN_TW-1:0] pair_q[$];
  crossing_t crossing_q[$];
  int errors = 0;
  int send_idle = 0;   // percent of cycles the sender idles
  int recv_idle = 0;   // percent of cycles the receiver stalls
  bit hold_off = 0;    // long receiver stall
  bit stim_done = 0;

  segment_intersection dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // trunc(p*2^F + tn*delta*2^F/d), 0 <= tn <= d, d > 0
  function automatic longint place_point(longint p, longint delta, longint tn, longint d);
    longint num, q, r, v;
    bit neg;
    neg = delta < 0;
    num = tn * (neg ? -delta : delta) * (64'sd1 <<< FRAC_BITS);
    q = num / d;
    r = num % d;
    v = p * (64'sd1 <<< FRAC_BITS) + (neg ? -q : q);
    if (r == 0) return v;
    if (!neg) return (v >= 0) ? v : v + 1;
    return (v > 0) ? v - 1 : v;
  endfunction

  function automatic crossing_t predict_crossing(logic [IN_TW-1:0] data);
    longint c[8];
    longint d, tn, un;
    crossing_t res;
    for (int i = 0; i < 8; i++)
      c[i] = longint'($signed(data[i*COORD_BITS +: COORD_BITS]));
    res = '0;
    d = (c[0]-c[2])*(c[5]-c[7]) - (c[1]-c[3])*(c[4]-c[6]);
    if (d == 0) return res;
    tn = (c[0]-c[4])*(c[5]-c[7]) - (c[1]-c[5])*(c[4]-c[6]);
    un = (c[1]-c[3])*(c[0]-c[4]) - (c[0]-c[2])*(c[1]-c[5]);
    if (d < 0) begin
      d = -d; tn = -tn; un = -un;
    end
    if (tn < 0 || tn > d || un < 0 || un > d) return res;
    res.hit = 1;
    res.cx = OUT_BITS'(place_point(c[0], c[2]-c[0], tn, d));
    res.cy = OUT_BITS'(place_point(c[1], c[3]-c[1], tn, d));
    return res;
  endfunction

  function automatic logic [IN_TW-1:0] pack_pair(int p[8]);
    logic [IN_TW-1:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) v[i*COORD_BITS +: COORD_BITS] = COORD_BITS'(p[i]);
    return v;
  endfunction

  function automatic int rand_coord(int span);
    return $urandom_range(2*span) - span;
  endfunction

  // half the pairs cluster around a random center, the first segment mirrored about it
  function automatic logic [IN_TW-1:0] rand_pair();
    int p[8];
    int span, cx, cy, mode;
    mode = $urandom_range(9);
    span = ($urandom_range(3) == 0) ? 32767 : (1 << $urandom_range(2, 13));
    if (mode < 5) begin
      cx = rand_coord(32767 - span);
      cy = rand_coord(32767 - span);
      for (int i = 0; i < 4; i++) begin
        p[2*i]   = cx + rand_coord(span);
        p[2*i+1] = cy + rand_coord(span);
      end
      p[2] = 2*cx - p[0]; p[3] = 2*cy - p[1];
      if (p[2] > 32767 || p[2] < -32768) p[2] = cx;
      if (p[3] > 32767 || p[3] < -32768) p[3] = cy;
    end else if (mode == 5) begin
      // parallel or collinear
      for (int i = 0; i < 4; i++) p[i] = rand_coord(span/2);
      p[4] = p[0] + 1; p[5] = p[1];
      p[6] = p[4] + (p[2]-p[0]); p[7] = p[5] + (p[3]-p[1]);
    end else if (mode == 6) begin
      // touching at a shared end point
      for (int i = 0; i < 6; i++) p[i] = rand_coord(span/2);
      p[6] = p[2]; p[7] = p[3];
    end else begin
      for (int i = 0; i < 8; i++) p[i] = $urandom_range(65535) - 32768;
    end
    return pack_pair(p);
  endfunction

  initial begin
    int p[8];
    int mx, mn;
    mx = 32767; mn = -32768;
    repeat (7) @(posedge clk);
    rst <= 0;
    // directed
    p = '{0,0,10,10, 0,10,10,0};               pair_q.push_back(pack_pair(p));
    p = '{0,0,10,0, 0,5,10,5};                 pair_q.push_back(pack_pair(p)); // parallel
    p = '{0,0,10,0, 2,0,20,0};                 pair_q.push_back(pack_pair(p)); // collinear
    p = '{3,3,3,3, 0,0,9,9};                   pair_q.push_back(pack_pair(p)); // zero length
    p = '{0,0,10,0, 10,0,10,10};               pair_q.push_back(pack_pair(p)); // touch end
    p = '{0,0,10,0, 0,-5,0,5};                 pair_q.push_back(pack_pair(p)); // touch start
    p = '{0,0,10,0, 11,-5,11,5};               pair_q.push_back(pack_pair(p)); // miss
    p = '{mn,mn,mx,mx, mn,mx,mx,mn};           pair_q.push_back(pack_pair(p));
    p = '{mx,mn,mn,mx, mn,mn,mx,mx};           pair_q.push_back(pack_pair(p));
    p = '{mn,0,mx,1, 0,mn,1,mx};               pair_q.push_back(pack_pair(p));
    p = '{mn,mn,mx,mn+1, mx,mx,mn,mn};         pair_q.push_back(pack_pair(p)); // wide result
    p = '{0,0,3,1, 0,1,3,0};                   pair_q.push_back(pack_pair(p)); // fraction
    p = '{0,0,-3,-1, 0,-1,-3,0};               pair_q.push_back(pack_pair(p)); // neg fraction
    p = '{-1,-1,-1,-1, -1,-1,-1,-1};           pair_q.push_back(pack_pair(p));
    p = '{mx,mx,mx,mx, mx,mx,mx,mx};           pair_q.push_back(pack_pair(p));
    pair_q.push_back({IN_TW{1'b1}});
    pair_q.push_back('0);
    wait (pair_q.size() == 0 && !s_tvalid && crossing_q.size() == 0);
    // phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 82 : 38) : 0;
      recv_idle = (ph == 2 || ph == 3) ? ((ph == 2) ? 82 : 38) : 0;
      for (int i = 0; i < 118; i++) pair_q.push_back(rand_pair());
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering
        for (int i = 0; i < 60; i++) pair_q.push_back(rand_pair());
        @(posedge clk);
        hold_off <= 1;
        repeat (200) @(posedge clk);
        hold_off <= 0;
      end
      wait (pair_q.size() == 0 && !s_tvalid && crossing_q.size() == 0);
    end
    stim_done = 1;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid && s_tready) crossing_q.push_back(predict_crossing(s_tdata));
      if (pair_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_tvalid <= 1;
        s_tdata <= pair_q.pop_front();
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    crossing_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[OUT_BITS:1], m_tdata[2*OUT_BITS:OUT_BITS+1]};
        if (crossing_q.size() == 0) begin
          $display("%t unexpected item %h", $time, m_tdata);
          errors++;
        end else begin
          want = crossing_q.pop_front();
          if (got.hit !== want.hit || got.cx !== want.cx || got.cy !== want.cy) begin
            $display("%t mismatch: expected hit=%b x=%h y=%h, actual hit=%b x=%h y=%h",
                     $time, want.hit, want.cx, want.cy, got.hit, got.cx, got.cy);
            errors++;
          end
        end
      end
      m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    wait (stim_done);
    repeat (60) @(posedge clk);
    if (errors == 0 && crossing_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
